// ===== sv/crc15_frame_checker_top_defines.svh =====
// ----------------------------------------------------------------------------
// crc15_frame_checker_top_defines.svh
// Assertion macros used by the frame checker's verification file crc15fc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef CRC15_FRAME_CHECKER_TOP_DEFINES_SVH
`define CRC15_FRAME_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CRC15FC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CRC15FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// ===== sv/crc15fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc15fc_pkg
// Types and constants of the CRC-15 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crc15fc_pkg;

  localparam int unsigned MAX_CHECKED_BYTES = 32;
  localparam int unsigned MIN_FRAME_BYTES   = 5;

  localparam int unsigned CRC_W  = 15;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHK_W  = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 15'h7FFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 15'h0F9D;

  // The byte counter saturates here; reaching it means the frame is too long.
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHECKED_BYTES + 3);
  // A frame is short when the position before its last byte is below this.
  localparam logic [POS_W-1:0] POS_SHORT = POS_W'(MIN_FRAME_BYTES - 1);
  // Bytes from this position on push a checked byte out of the delay.
  localparam logic [POS_W-1:0] POS_FOLD  = POS_W'(3);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_LONG     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [CHK_W-1:0] received_check;
    logic [CHK_W-1:0] computed_check;
    status_e          status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/crc15_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc15_frame_checker_top
// Checks the CRC-15 of a received serial bus frame, one byte per beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata[1:0] status, [17:2] computed_check,
//                       [33:18] received_check, [39:34] zero
//
//  One byte per cycle is sustained while no result beat is stalled; the
//  byte-wide CRC update sits between the input register and the result
//  register. Only the last byte of a frame produces a result beat. Reset
//  returns the frame state to its start and empties both registers. A stalled
//  result beat holds the byte in the input register, and a new beat is taken
//  then only while that register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crc15_frame_checker_top
  import crc15fc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tlast,  // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // status, computed_check, received_check
);

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           result;
  logic              out_free;
  logic              advance;
  logic              in_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  crc15fc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .data_i   (in_data_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - RESULT_W)'(0), out_q};

endmodule

`default_nettype wire

// ===== sv/crc15fc_byte_fold.sv =====
// ----------------------------------------------------------------------------
// crc15fc_byte_fold
// Folds one byte into a CRC-15 register, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module crc15fc_byte_fold
  import crc15fc_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic [CRC_W-1:0]  crc_o
);

  always_comb begin
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = crc_i;
    for (int k = 0; k < BYTE_W; k++) begin
      fb  = crc[CRC_W-1] ^ byte_i[BYTE_W-1-k];
      crc = {crc[CRC_W-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    crc_o = crc;
  end

endmodule

`default_nettype wire

// ===== sv/crc15fc_frame.sv =====
// ----------------------------------------------------------------------------
// crc15fc_frame
// Per-frame state: byte counter, two-byte delay, CRC register and status.
// ----------------------------------------------------------------------------
`default_nettype none

module crc15fc_frame
  import crc15fc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] data_i,
  input  logic              last_i,
  output result_t           result_o
);

  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] older_q, older_d;
  logic [BYTE_W-1:0] newer_q, newer_d;
  logic [CRC_W-1:0]  crc_folded;
  logic [CRC_W-1:0]  crc_new;
  logic [CHK_W-1:0]  computed;
  logic [CHK_W-1:0]  received;

  crc15fc_byte_fold u_fold (
    .crc_i  (crc_q),
    .byte_i (older_q),
    .crc_o  (crc_folded)
  );

  // The byte leaving the delay is skipped while it is still the start byte.
  assign crc_new  = (pos_q >= POS_FOLD) ? crc_folded : crc_q;
  assign computed = {crc_new ^ CRC_INIT, 1'b0};
  assign received = {newer_q, data_i};

  always_comb begin
    result_o.computed_check = computed;
    result_o.received_check = received;
    if (pos_q < POS_SHORT) begin
      result_o.status = ST_SHORT;
    end else if (pos_q >= POS_LIMIT) begin
      result_o.status = ST_LONG;
    end else if (computed != received) begin
      result_o.status = ST_MISMATCH;
    end else begin
      result_o.status = ST_OK;
    end
  end

  always_comb begin
    crc_d   = crc_q;
    pos_d   = pos_q;
    older_d = older_q;
    newer_d = newer_q;
    if (step_i) begin
      if (last_i) begin
        crc_d   = CRC_INIT;
        pos_d   = '0;
        older_d = '0;
        newer_d = '0;
      end else begin
        crc_d   = crc_new;
        older_d = newer_q;
        newer_d = data_i;
        if (pos_q < POS_LIMIT) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      pos_q   <= '0;
      older_q <= '0;
      newer_q <= '0;
    end else begin
      crc_q   <= crc_d;
      pos_q   <= pos_d;
      older_q <= older_d;
      newer_q <= newer_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crc15fc_checker.sv =====
// ----------------------------------------------------------------------------
// crc15fc_checker
// Port-level checks of the frame checker's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc15_frame_checker_top_defines.svh"

module crc15fc_checker
  import crc15fc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  // A stalled result beat keeps its payload.
  `CRC15FC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // An ok status means both check words agree.
  `CRC15FC_ASSERT_IMPL(a_ok_equal, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK), m_axis_tdata[17:2] == m_axis_tdata[33:18])

  // A mismatch status means the check words differ.
  `CRC15FC_ASSERT_IMPL(a_mismatch_differ, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] == ST_MISMATCH), m_axis_tdata[17:2] != m_axis_tdata[33:18])

  // The computed word is the inverted CRC shifted left, so its lowest bit is clear.
  `CRC15FC_ASSERT_IMPL(a_computed_lsb, clk_i, rst_ni, m_axis_tvalid, !m_axis_tdata[2])

endmodule

bind crc15_frame_checker_top crc15fc_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
